FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define TLVD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion that also checks during reset
`define TLVD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/tlvd_pkg.sv
// types and constants of the tlv container deframer
// no dependencies
package tlvd_pkg;

    localparam int ByteW   = 8;
    localparam int LenW    = 32;
    localparam int KindW   = 3;
    localparam int CountW  = 3;
    localparam int HdrBytes = 6;
    localparam int LenBytes = 4;

    typedef enum logic [2:0] {
        PH_VERSION,
        PH_CTAG,
        PH_CLEN,
        PH_RTAG,
        PH_RLEN,
        PH_DATA,
        PH_TRAILER,
        PH_SKIP
    } t_phase;

    typedef enum logic [KindW-1:0] {
        EV_HEADER,
        EV_CONTAINER,
        EV_RECORD,
        EV_DATA,
        EV_TRAILER,
        EV_VERSION_ERR,
        EV_OVERRUN,
        EV_SKIPPED
    } t_kind;

    typedef struct packed {
        t_phase            phase;
        logic [CountW-1:0] field_cnt;
        logic [LenW-1:0]   container_left;
        logic [LenW-1:0]   record_left;
        logic [LenW-1:0]   length_shift;
        logic [ByteW-1:0]  container_tag;
        logic [ByteW-1:0]  record_tag;
    } t_state;

    typedef struct packed {
        t_kind            kind;
        logic [ByteW-1:0] tag;
        logic [LenW-1:0]  len;
        logic [ByteW-1:0] pay;
        logic             last;
        logic             done;
    } t_result;

    localparam t_state StateReset = '{
        phase:          PH_VERSION,
        field_cnt:      '0,
        container_left: '0,
        record_left:    '0,
        length_shift:   '0,
        container_tag:  '0,
        record_tag:     '0
    };

endpackage

FILE: hw/rtl/tlvd_if.sv
// valid/ready channels of the tlv container deframer
// depends on tlvd_pkg
interface tlvd_in_if;
    logic                      valid;
    logic                      ready;
    logic [tlvd_pkg::ByteW-1:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface tlvd_out_if;
    logic                       valid;
    logic                       ready;
    logic [tlvd_pkg::KindW-1:0] event_kind;
    logic [tlvd_pkg::ByteW-1:0] tag_value;
    logic [tlvd_pkg::LenW-1:0]  length_value;
    logic [tlvd_pkg::ByteW-1:0] payload_byte;
    logic                       record_last;
    logic                       container_done;

    modport source (
        output valid, output event_kind, output tag_value, output length_value,
        output payload_byte, output record_last, output container_done,
        input ready
    );
    modport sink (
        input valid, input event_kind, input tag_value, input length_value,
        input payload_byte, input record_last, input container_done,
        output ready
    );
endinterface

FILE: hw/rtl/tlvd_step.sv
// next-state and result logic for one stream byte
// depends on tlvd_pkg
module tlvd_step (
    input  tlvd_pkg::t_state             i_state,
    input  logic [tlvd_pkg::ByteW-1:0]   i_byte,
    input  logic [tlvd_pkg::ByteW-1:0]   i_expected_version,
    output tlvd_pkg::t_state             o_state,
    output tlvd_pkg::t_result            o_result
);
    import tlvd_pkg::*;

    logic [LenW-1:0]   shifted;
    logic [LenW-1:0]   left_dec;
    logic [LenW-1:0]   rec_dec;
    logic [CountW-1:0] cnt_inc;
    logic [LenW:0]     need;
    logic              len_full;

    assign shifted  = {i_state.length_shift[LenW-ByteW-1:0], i_byte};
    assign left_dec = i_state.container_left - LenW'(1);
    assign rec_dec  = i_state.record_left - LenW'(1);
    assign cnt_inc  = i_state.field_cnt + CountW'(1);
    assign need     = {1'b0, shifted} + (LenW+1)'(1);
    assign len_full = (cnt_inc >= CountW'(LenBytes));

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        unique case (i_state.phase)
            PH_VERSION: begin
                if (i_byte == i_expected_version) begin
                    o_state.phase = PH_CTAG;
                end else begin
                    o_result.kind = EV_VERSION_ERR;
                end
            end
            PH_CTAG: begin
                o_state.container_tag = i_byte;
                o_state.field_cnt     = '0;
                o_state.length_shift  = '0;
                o_state.phase         = PH_CLEN;
            end
            PH_CLEN: begin
                o_state.length_shift = shifted;
                o_state.field_cnt    = cnt_inc;
                if (len_full) begin
                    o_result.kind          = EV_CONTAINER;
                    o_result.tag           = i_state.container_tag;
                    o_result.len           = shifted;
                    o_state.container_left = shifted;
                    if (shifted == '0) begin
                        o_result.done = 1'b1;
                        o_state.phase = PH_VERSION;
                    end else begin
                        o_state.phase = PH_RTAG;
                    end
                end
            end
            PH_RTAG: begin
                o_state.container_left = left_dec;
                if (i_state.container_left < LenW'(HdrBytes)) begin
                    // not enough room for a record header
                    o_result.kind = EV_OVERRUN;
                    if (left_dec == '0) begin
                        o_result.done = 1'b1;
                        o_state.phase = PH_VERSION;
                    end else begin
                        o_state.phase = PH_SKIP;
                    end
                end else begin
                    o_state.record_tag   = i_byte;
                    o_state.field_cnt    = '0;
                    o_state.length_shift = '0;
                    o_state.phase        = PH_RLEN;
                end
            end
            PH_RLEN: begin
                o_state.length_shift   = shifted;
                o_state.field_cnt      = cnt_inc;
                o_state.container_left = left_dec;
                if (len_full) begin
                    // data plus trailer must fit in the room left
                    if (need > {1'b0, left_dec}) begin
                        o_result.kind = EV_OVERRUN;
                        if (left_dec == '0) begin
                            o_result.done = 1'b1;
                            o_state.phase = PH_VERSION;
                        end else begin
                            o_state.phase = PH_SKIP;
                        end
                    end else begin
                        o_result.kind       = EV_RECORD;
                        o_result.tag        = i_state.record_tag;
                        o_result.len        = shifted;
                        o_state.record_left = shifted;
                        o_state.phase       = (shifted == '0) ? PH_TRAILER : PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                o_result.kind          = EV_DATA;
                o_result.tag           = i_state.record_tag;
                o_result.pay           = i_byte;
                o_state.record_left    = rec_dec;
                o_state.container_left = left_dec;
                if (rec_dec == '0) begin
                    o_result.last = 1'b1;
                    o_state.phase = PH_TRAILER;
                end
            end
            PH_TRAILER: begin
                o_result.kind          = EV_TRAILER;
                o_state.container_left = left_dec;
                if (left_dec == '0) begin
                    o_result.done = 1'b1;
                    o_state.phase = PH_VERSION;
                end else begin
                    o_state.phase = PH_RTAG;
                end
            end
            PH_SKIP: begin
                o_result.kind = EV_SKIPPED;
                if (i_state.container_left == '0) begin
                    o_result.done = 1'b1;
                    o_state.phase = PH_VERSION;
                end else begin
                    o_state.container_left = left_dec;
                    if (left_dec == '0) begin
                        o_result.done = 1'b1;
                        o_state.phase = PH_VERSION;
                    end
                end
            end
            default: begin
                o_state.phase = PH_VERSION;
            end
        endcase
    end

endmodule

FILE: hw/rtl/tlv_container_deframer.sv
// tlv container deframer: one stream byte in, one event word out per byte
// each byte passes an input register and then a result register before its word is valid
// throughput: one byte per cycle while the output is not stalled; the byte step logic is a 32-bit decrement and compare
// reset: synchronous active-low i_rst_n clears both valid flags, the parser state
// and expected_version; the parser then waits for a version byte
module tlv_container_deframer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tlvd_pkg::ByteW-1:0] i_cfg_wdata,
    tlvd_in_if.sink                    i_in,
    tlvd_out_if.source                 o_out
);
    import tlvd_pkg::*;

    // expected version register
    logic [ByteW-1:0] r_ver;

    // input stage: raw byte held until the step logic can take it
    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;

    // parser state and result stage
    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;

    logic res_ready;
    logic advance;

    // result register frees when empty or when its word is taken
    assign res_ready  = !r_out_valid || o_out.ready;
    // input stage frees when empty or when it moves on to the result
    assign i_in.ready = !r_in_valid || res_ready;
    assign advance    = r_in_valid && res_ready;

    tlvd_step u_step (
        .i_state            (r_state),
        .i_byte             (r_in_byte),
        .i_expected_version (r_ver),
        .o_state            (n_state),
        .o_result           (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ver <= '0;
        end else if (i_cfg_we) begin
            r_ver <= i_cfg_wdata;
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.stream_byte;
        end
    end

    // parser state moves only when a byte is stepped into the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StateReset;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.event_kind     = r_result.kind;
    assign o_out.tag_value      = r_result.tag;
    assign o_out.length_value   = r_result.len;
    assign o_out.payload_byte   = r_result.pay;
    assign o_out.record_last    = r_result.last;
    assign o_out.container_done = r_result.done;

endmodule

FILE: hw/rtl/tlvd_checker.sv
// port-level checks of the tlv container deframer, bound to the top level
// depends on tlvd_pkg and assert_macros.svh
`include "assert_macros.svh"

module tlvd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [tlvd_pkg::KindW-1:0] i_event_kind,
    input logic [tlvd_pkg::ByteW-1:0] i_tag_value,
    input logic [tlvd_pkg::LenW-1:0]  i_length_value,
    input logic [tlvd_pkg::ByteW-1:0] i_payload_byte,
    input logic                       i_record_last,
    input logic                       i_container_done
);
    import tlvd_pkg::*;

    // a stalled word keeps its kind and tag
    `TLVD_ASSERT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_event_kind) && $stable(i_tag_value), "output word changed while stalled")

    // last flag only on a data byte
    `TLVD_ASSERT(a_last_data, i_clk, i_rst_n, i_out_valid && i_record_last |-> i_event_kind == EV_DATA, "record_last on a non-data word")

    // container end only on an empty header, trailer, overrun or skipped byte
    `TLVD_ASSERT(a_done_kind, i_clk, i_rst_n, i_out_valid && i_container_done |-> (i_event_kind == EV_CONTAINER && i_length_value == '0) || i_event_kind == EV_TRAILER || i_event_kind == EV_OVERRUN || i_event_kind == EV_SKIPPED, "container_done on an unexpected word")

    // a version error carries no other information
    `TLVD_ASSERT(a_ver_clean, i_clk, i_rst_n, i_out_valid && i_event_kind == EV_VERSION_ERR |-> i_tag_value == '0 && i_length_value == '0 && i_payload_byte == '0 && !i_record_last && !i_container_done, "version error word has stray fields")

    // reset empties the result stage
    `TLVD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

endmodule

bind tlv_container_deframer tlvd_checker u_tlvd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_event_kind     (o_out.event_kind),
    .i_tag_value      (o_out.tag_value),
    .i_length_value   (o_out.length_value),
    .i_payload_byte   (o_out.payload_byte),
    .i_record_last    (o_out.record_last),
    .i_container_done (o_out.container_done)
);
